// File: rtl/mpm_pkg.sv
// ----------------------------------------------------------------------------
// Multi-pattern matcher package
// Sizes, codes and beat types shared by the matcher RTL.
// ----------------------------------------------------------------------------
package mpm_pkg;

    localparam int MaxNodes    = 256;
    localparam int MaxPatterns = 32;
    localparam int PosBits     = 16;

    localparam int SymBits   = 8;
    localparam int NodeBits  = $clog2(MaxNodes);
    localparam int NcntBits  = $clog2(MaxNodes + 1);
    localparam int PcntBits  = $clog2(MaxPatterns + 1);
    localparam int GotoAw    = NodeBits + SymBits;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_BUILD  = 2'd1,
        OP_SEARCH = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_MATCH     = 2'd1,
        ST_NODE_FULL = 2'd2,
        ST_PAT_FULL  = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] symbol;
        logic       word_end;
        logic       text_start;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  pattern_id;
        logic [15:0] start_index;
        logic        last;
    } t_out_item;

endpackage

// File: rtl/multi_pattern_matcher_unit.sv
// ----------------------------------------------------------------------------
// Multi-pattern matcher
// Byte-alphabet trie in a goto memory, breadth-first link build and a
// streaming text search that reports every pattern ending at each byte.
// ----------------------------------------------------------------------------
//   channel | signals                          | beat
//   --------+----------------------------------+---------------------------
//   input   | i_in_valid  o_in_ready  i_in_data | op, byte, word end, restart
//   output  | o_out_valid i_out_ready o_out_data| status, id, start, last
//
// Add reads the goto entry under the cursor, then marks a word end. Search
// follows fail links, then reports each match; all steps go through one
// goto read port and one node read port. Build queues the root children,
// then for every node reads each symbol and follows fail links per child.
// After reset a clearing pass writes the whole goto memory with o_in_ready
// low. A stalled output holds the next result in place.
module multi_pattern_matcher_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mpm_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mpm_pkg::t_out_item  o_out_data
);
    import mpm_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_ADD1, S_ADD2, S_DONE,
        S_B_RREAD, S_B_RCHK, S_B_POP, S_B_U, S_B_UF, S_B_CREAD, S_B_CCHK,
        S_B_FWALK, S_B_FCHK, S_B_FNEXT, S_B_W,
        S_WALK, S_CHK, S_FN, S_O0, S_OCHK
    } t_state;

    // memories
    logic [NodeBits-1:0] r_goto_mem  [2**GotoAw];
    logic [NodeBits-1:0] r_fail_mem  [MaxNodes];
    logic [NodeBits-1:0] r_olink_mem [MaxNodes];
    logic [PcntBits-1:0] r_npat_mem  [MaxNodes];
    logic [NodeBits-1:0] r_depth_mem [MaxNodes];
    logic [NodeBits-1:0] r_queue_mem [MaxNodes];

    logic [NodeBits-1:0] r_goto_q, r_fail_q, r_olink_q, r_depth_q, r_queue_q;
    logic [PcntBits-1:0] r_npat_q;

    logic                goto_we;
    logic [GotoAw-1:0]   goto_waddr, goto_raddr;
    logic [NodeBits-1:0] goto_wdata;
    logic [NodeBits-1:0] nd_raddr, nd_waddr;
    logic                nd_fail_we, nd_olink_we, nd_npat_we, nd_depth_we;
    logic [NodeBits-1:0] nd_fail_wd, nd_olink_wd, nd_depth_wd;
    logic [PcntBits-1:0] nd_npat_wd;
    logic                q_we;
    logic [NodeBits-1:0] q_waddr, q_wdata, q_raddr;

    // control registers
    t_state              r_state, n_state;
    logic [GotoAw-1:0]   r_clr, n_clr;
    logic [NcntBits-1:0] r_ncnt, n_ncnt;
    logic [PcntBits-1:0] r_pcnt, n_pcnt;
    logic [NodeBits-1:0] r_cursor, n_cursor;
    logic [NodeBits-1:0] r_depth, n_depth;
    logic                r_broken, n_broken;
    logic [NodeBits-1:0] r_mnode, n_mnode;
    logic [PosBits-1:0]  r_tpos, n_tpos;
    logic [SymBits-1:0]  r_sym, n_sym;
    logic                r_wend, n_wend;
    logic                r_new, n_new;
    logic                r_cok, n_cok;
    logic [NodeBits-1:0] r_c, n_c;
    t_status             r_status, n_status;
    logic [SymBits-1:0]  r_s, n_s;
    logic [NcntBits-1:0] r_head, n_head;
    logic [NcntBits-1:0] r_tail, n_tail;
    logic [NodeBits-1:0] r_u, n_u;
    logic [NodeBits-1:0] r_fu, n_fu;
    logic [NodeBits-1:0] r_v, n_v;
    logic [NodeBits-1:0] r_f, n_f;
    logic [NodeBits-1:0] r_w, n_w;
    logic [NcntBits-1:0] r_steps, n_steps;
    logic [NodeBits-1:0] r_node, n_node;
    logic [PosBits-1:0]  r_pos, n_pos;
    logic [NodeBits-1:0] r_o, n_o;
    logic [PcntBits-1:0] r_k, n_k;
    logic                r_pend, n_pend;
    logic [4:0]          r_pid, n_pid;
    logic [15:0]         r_pstart, n_pstart;
    logic                r_ovalid, n_ovalid;
    t_out_item           r_odata, n_odata;

    logic                out_free;
    logic                in_fire;
    logic [NodeBits-1:0] t_node, t_w;
    logic [PosBits-1:0]  t_start;

    assign out_free    = !r_ovalid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

    always_ff @(posedge i_clk) begin
        if (goto_we) begin
            r_goto_mem[goto_waddr] <= goto_wdata;
        end
        r_goto_q <= r_goto_mem[goto_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (nd_fail_we) begin
            r_fail_mem[nd_waddr] <= nd_fail_wd;
        end
        if (nd_olink_we) begin
            r_olink_mem[nd_waddr] <= nd_olink_wd;
        end
        if (nd_npat_we) begin
            r_npat_mem[nd_waddr] <= nd_npat_wd;
        end
        if (nd_depth_we) begin
            r_depth_mem[nd_waddr] <= nd_depth_wd;
        end
        r_fail_q  <= r_fail_mem[nd_raddr];
        r_olink_q <= r_olink_mem[nd_raddr];
        r_npat_q  <= r_npat_mem[nd_raddr];
        r_depth_q <= r_depth_mem[nd_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_queue_mem[q_waddr] <= q_wdata;
        end
        r_queue_q <= r_queue_mem[q_raddr];
    end

    always_comb begin
        n_state = r_state;   n_clr = r_clr;       n_ncnt = r_ncnt;
        n_pcnt = r_pcnt;     n_cursor = r_cursor; n_depth = r_depth;
        n_broken = r_broken; n_mnode = r_mnode;   n_tpos = r_tpos;
        n_sym = r_sym;       n_wend = r_wend;     n_new = r_new;
        n_cok = r_cok;       n_c = r_c;           n_status = r_status;
        n_s = r_s;           n_head = r_head;     n_tail = r_tail;
        n_u = r_u;           n_fu = r_fu;         n_v = r_v;
        n_f = r_f;           n_w = r_w;           n_steps = r_steps;
        n_node = r_node;     n_pos = r_pos;       n_o = r_o;
        n_k = r_k;           n_pend = r_pend;     n_pid = r_pid;
        n_pstart = r_pstart;
        n_ovalid = r_ovalid && !i_out_ready;
        n_odata  = r_odata;

        goto_we = 1'b0; goto_waddr = '0; goto_wdata = '0; goto_raddr = '0;
        nd_raddr = r_o; nd_waddr = '0;
        nd_fail_we = 1'b0; nd_olink_we = 1'b0; nd_npat_we = 1'b0; nd_depth_we = 1'b0;
        nd_fail_wd = '0; nd_olink_wd = '0; nd_npat_wd = '0; nd_depth_wd = '0;
        q_we = 1'b0; q_waddr = r_tail[NodeBits-1:0]; q_wdata = '0;
        q_raddr = r_head[NodeBits-1:0];
        t_node = '0; t_w = '0; t_start = '0;

        unique case (r_state)
            S_CLEAR: begin
                goto_we    = 1'b1;
                goto_waddr = r_clr;
                n_clr      = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (in_fire) begin
                    n_sym   = i_in_data.symbol;
                    n_wend  = i_in_data.word_end;
                    n_steps = '0;
                    unique case (i_in_data.operation)
                        OP_ADD: begin
                            goto_raddr = {r_cursor, i_in_data.symbol};
                            n_state    = S_ADD1;
                        end
                        OP_BUILD: begin
                            n_s = '0; n_head = '0; n_tail = '0;
                            n_state = S_B_RREAD;
                        end
                        OP_SEARCH: begin
                            n_node  = i_in_data.text_start ? '0 : r_mnode;
                            n_pos   = i_in_data.text_start ? '0 : r_tpos;
                            n_k     = '0;
                            n_pend  = 1'b0;
                            n_state = S_WALK;
                        end
                        default: begin
                            n_status = ST_DONE;
                            n_state  = S_DONE;
                        end
                    endcase
                end
            end

            S_ADD1: begin
                n_status = ST_DONE;
                n_new    = 1'b0;
                n_cok    = 1'b0;
                t_node   = r_goto_q;
                if (r_broken) begin
                    n_status = ST_NODE_FULL;
                end else if (r_goto_q == '0) begin
                    if (r_ncnt >= NcntBits'(MaxNodes)) begin
                        n_status = ST_NODE_FULL;
                        if (!r_wend) begin
                            n_broken = 1'b1;
                        end
                    end else begin
                        // allocate a fresh node and hang it under the cursor
                        t_node      = r_ncnt[NodeBits-1:0];
                        n_ncnt      = r_ncnt + 1'b1;
                        goto_we     = 1'b1;
                        goto_waddr  = {r_cursor, r_sym};
                        goto_wdata  = t_node;
                        nd_waddr    = t_node;
                        nd_fail_we  = 1'b1;
                        nd_olink_we = 1'b1;
                        nd_npat_we  = 1'b1;
                        nd_depth_we = 1'b1;
                        nd_depth_wd = r_depth + 1'b1;
                        n_new       = 1'b1;
                        n_cok       = 1'b1;
                    end
                end else begin
                    n_cok = 1'b1;
                end
                if (n_cok) begin
                    n_c      = t_node;
                    n_cursor = t_node;
                    n_depth  = r_depth + 1'b1;
                end
                nd_raddr = t_node;
                n_state  = S_ADD2;
            end

            S_ADD2: begin
                nd_raddr = r_c;
                if (out_free) begin
                    n_status = r_status;
                    // a fresh node reads stale data: it has no pattern yet
                    if (r_cok && r_wend && (r_new || r_npat_q == '0)) begin
                        if (r_pcnt >= PcntBits'(MaxPatterns)) begin
                            n_status = ST_PAT_FULL;
                        end else begin
                            nd_waddr   = r_c;
                            nd_npat_we = 1'b1;
                            nd_npat_wd = r_pcnt + 1'b1;
                            n_pcnt     = r_pcnt + 1'b1;
                        end
                    end
                    if (r_wend) begin
                        n_cursor = '0;
                        n_depth  = '0;
                        n_broken = 1'b0;
                    end
                    n_ovalid = 1'b1;
                    n_odata  = '{status: n_status, pattern_id: '0, start_index: '0,
                                 last: 1'b1};
                    n_state  = S_IDLE;
                end
            end

            S_DONE: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_odata  = '{status: r_status, pattern_id: '0, start_index: '0,
                                 last: 1'b1};
                    n_state  = S_IDLE;
                end
            end

            S_B_RREAD: begin
                goto_raddr = {NodeBits'(0), r_s};
                n_state    = S_B_RCHK;
            end

            S_B_RCHK: begin
                if (r_goto_q != '0) begin
                    nd_waddr    = r_goto_q;
                    nd_fail_we  = 1'b1;
                    nd_olink_we = 1'b1;
                    q_we        = 1'b1;
                    q_wdata     = r_goto_q;
                    n_tail      = r_tail + 1'b1;
                end
                n_s     = r_s + 1'b1;
                n_state = (r_s == '1) ? S_B_POP : S_B_RREAD;
            end

            S_B_POP: begin
                if (r_head == r_tail) begin
                    n_status = ST_DONE;
                    n_state  = S_DONE;
                end else begin
                    n_head  = r_head + 1'b1;
                    n_state = S_B_U;
                end
            end

            S_B_U: begin
                n_u      = r_queue_q;
                nd_raddr = r_queue_q;
                n_s      = '0;
                n_state  = S_B_UF;
            end

            S_B_UF: begin
                n_fu    = r_fail_q;
                n_state = S_B_CREAD;
            end

            S_B_CREAD: begin
                goto_raddr = {r_u, r_s};
                n_state    = S_B_CCHK;
            end

            S_B_CCHK: begin
                if (r_goto_q == '0) begin
                    n_s     = r_s + 1'b1;
                    n_state = (r_s == '1) ? S_B_POP : S_B_CREAD;
                end else begin
                    n_v     = r_goto_q;
                    n_f     = r_fu;
                    n_steps = '0;
                    n_state = S_B_FWALK;
                end
            end

            S_B_FWALK: begin
                goto_raddr = {r_f, r_s};
                n_state    = S_B_FCHK;
            end

            S_B_FCHK: begin
                if (r_f != '0 && r_goto_q == '0 && r_steps < NcntBits'(MaxNodes)) begin
                    nd_raddr = r_f;
                    n_state  = S_B_FNEXT;
                end else begin
                    t_w        = (r_goto_q == r_v) ? '0 : r_goto_q;
                    n_w        = t_w;
                    nd_waddr   = r_v;
                    nd_fail_we = 1'b1;
                    nd_fail_wd = t_w;
                    nd_raddr   = t_w;
                    n_state    = S_B_W;
                end
            end

            S_B_FNEXT: begin
                n_f     = r_fail_q;
                n_steps = r_steps + 1'b1;
                n_state = S_B_FWALK;
            end

            S_B_W: begin
                nd_waddr    = r_v;
                nd_olink_we = 1'b1;
                if (r_w == '0) begin
                    nd_olink_wd = '0;
                end else begin
                    nd_olink_wd = (r_npat_q != '0) ? r_w : r_olink_q;
                end
                q_we    = 1'b1;
                q_wdata = r_v;
                n_tail  = r_tail + 1'b1;
                n_s     = r_s + 1'b1;
                n_state = (r_s == '1) ? S_B_POP : S_B_CREAD;
            end

            S_WALK: begin
                goto_raddr = {r_node, r_sym};
                n_state    = S_CHK;
            end

            S_CHK: begin
                if (r_node != '0 && r_goto_q == '0 && r_steps < NcntBits'(MaxNodes)) begin
                    nd_raddr = r_node;
                    n_state  = S_FN;
                end else begin
                    n_node   = r_goto_q;
                    n_mnode  = r_goto_q;
                    n_tpos   = r_pos + 1'b1;
                    nd_raddr = r_goto_q;
                    n_state  = S_O0;
                end
            end

            S_FN: begin
                n_node  = r_fail_q;
                n_steps = r_steps + 1'b1;
                n_state = S_WALK;
            end

            S_O0: begin
                if (r_node == '0) begin
                    t_node = '0;
                end else begin
                    t_node = (r_npat_q != '0) ? r_node : r_olink_q;
                end
                n_o      = t_node;
                nd_raddr = t_node;
                n_state  = S_OCHK;
            end

            S_OCHK: begin
                // one match is held back so that the final one carries last
                if (r_o != '0 && r_npat_q != '0 && r_k < PcntBits'(MaxPatterns)) begin
                    if (!r_pend || out_free) begin
                        if (r_pend) begin
                            n_ovalid = 1'b1;
                            n_odata  = '{status: ST_MATCH, pattern_id: r_pid,
                                         start_index: r_pstart, last: 1'b0};
                        end
                        t_start  = r_pos + PosBits'(1) - PosBits'(r_depth_q);
                        n_pend   = 1'b1;
                        n_pid    = 5'(r_npat_q - 1'b1);
                        n_pstart = 16'(t_start);
                        n_k      = r_k + 1'b1;
                        n_o      = r_olink_q;
                        nd_raddr = r_olink_q;
                    end
                end else if (out_free) begin
                    n_ovalid = 1'b1;
                    if (r_pend) begin
                        n_odata = '{status: ST_MATCH, pattern_id: r_pid,
                                    start_index: r_pstart, last: 1'b1};
                    end else begin
                        n_odata = '{status: ST_DONE, pattern_id: '0, start_index: '0,
                                    last: 1'b1};
                    end
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ncnt   <= NcntBits'(1);
            r_pcnt   <= '0;
            r_cursor <= '0;
            r_depth  <= '0;
            r_broken <= 1'b0;
            r_mnode  <= '0;
            r_tpos   <= '0;
            r_head   <= '0;
            r_tail   <= '0;
            r_k      <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_ncnt   <= n_ncnt;
            r_pcnt   <= n_pcnt;
            r_cursor <= n_cursor;
            r_depth  <= n_depth;
            r_broken <= n_broken;
            r_mnode  <= n_mnode;
            r_tpos   <= n_tpos;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_k      <= n_k;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
        r_sym    <= n_sym;
        r_wend   <= n_wend;
        r_new    <= n_new;
        r_cok    <= n_cok;
        r_c      <= n_c;
        r_status <= n_status;
        r_s      <= n_s;
        r_u      <= n_u;
        r_fu     <= n_fu;
        r_v      <= n_v;
        r_f      <= n_f;
        r_w      <= n_w;
        r_steps  <= n_steps;
        r_node   <= n_node;
        r_pos    <= n_pos;
        r_o      <= n_o;
        r_pid    <= n_pid;
        r_pstart <= n_pstart;
        r_odata  <= n_odata;
    end

`ifndef SYNTHESIS
    a_one_item_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_in_ready)
        else $error("input taken while an item is still at work");

    a_node_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ncnt <= NcntBits'(MaxNodes) && r_ncnt != '0)
        else $error("node count out of range");

    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail)
        else $error("breadth-first queue read past its tail");

    a_match_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= PcntBits'(MaxPatterns))
        else $error("too many matches for one text byte");
`endif

endmodule

// File: tb/multi_pattern_matcher_unit_tb.sv
// ----------------------------------------------------------------------------
// Multi-pattern matcher testbench
// Drives add, build and search beats into the matcher with random gaps on
// both channels. A behavioural trie with fail and output links predicts
// every result beat. A short directed table comes first, then random rounds
// of words, builds and texts. A final phase fills the node store.
// ----------------------------------------------------------------------------
module multi_pattern_matcher_unit_tb;
    import mpm_pkg::*;

    localparam int CycleLimit = 5000000;
    localparam int RandItems  = 160;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;

    multi_pattern_matcher_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Trie mirror
    int        trie_child [MaxNodes][256];
    int        fail_of [MaxNodes];
    int        out_link_of [MaxNodes];
    int        pat_at [MaxNodes];
    int        pat_len [MaxPatterns];
    int        n_nodes = 1;
    int        n_pats = 0;
    int        cursor = 0;
    int        depth = 0;
    bit        word_dropped = 0;
    int        scan_node = 0;
    int        scan_pos = 0;

    t_out_item pending_beats[$];
    int        errors = 0;
    int        cycles = 0;
    bit        no_gaps = 0;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_row;

    t_row      rows[$];

    function automatic t_out_item beat(t_status st, int id, int start, bit lst);
        t_out_item b;
        b.status      = st;
        b.pattern_id  = id[4:0];
        b.start_index = start[15:0];
        b.last        = lst;
        return b;
    endfunction

    function automatic void expect_beat(t_out_item b);
        pending_beats.insert(pending_beats.size(), b);
    endfunction

    function automatic void add_row(t_in_item it, bit typed, t_out_item want);
        t_row rw;
        rw.item  = it;
        rw.typed = typed;
        rw.want  = want;
        rows.insert(rows.size(), rw);
    endfunction

    function automatic t_status insert_byte(int sym, bit we);
        t_status st = ST_DONE;
        int c;
        if (word_dropped) begin
            st = ST_NODE_FULL;
        end else begin
            c = trie_child[cursor][sym];
            if (c == 0) begin
                if (n_nodes >= MaxNodes) begin
                    st = ST_NODE_FULL;
                    if (!we) word_dropped = 1;
                end else begin
                    c = n_nodes++;
                    trie_child[cursor][sym] = c;
                    fail_of[c] = 0;
                    out_link_of[c] = 0;
                    pat_at[c] = 0;
                end
            end
            if (c != 0) begin
                cursor = c;
                depth++;
                if (we && pat_at[c] == 0) begin
                    if (n_pats >= MaxPatterns) begin
                        st = ST_PAT_FULL;
                    end else begin
                        pat_len[n_pats] = depth;
                        n_pats++;
                        pat_at[c] = n_pats;
                    end
                end
            end
        end
        if (we) begin
            cursor = 0;
            depth = 0;
            word_dropped = 0;
        end
        return st;
    endfunction

    function automatic void link_trie();
        int fifo[$];
        int u, v, f, w, steps;
        for (int s = 0; s < 256; s++) begin
            v = trie_child[0][s];
            if (v != 0) begin
                fail_of[v] = 0;
                out_link_of[v] = 0;
                fifo.insert(fifo.size(), v);
            end
        end
        while (fifo.size() > 0) begin
            u = fifo.pop_front();
            for (int s = 0; s < 256; s++) begin
                v = trie_child[u][s];
                if (v != 0) begin
                    f = fail_of[u];
                    steps = 0;
                    while (f != 0 && trie_child[f][s] == 0 && steps < MaxNodes) begin
                        f = fail_of[f];
                        steps++;
                    end
                    w = trie_child[f][s];
                    if (w == v) w = 0;
                    fail_of[v] = w;
                    out_link_of[v] = (pat_at[w] != 0) ? w : out_link_of[w];
                    fifo.insert(fifo.size(), v);
                end
            end
        end
    endfunction

    function automatic void scan_byte(int sym, bit restart);
        int node, pos, steps, o, k, id;
        if (restart) begin
            scan_node = 0;
            scan_pos = 0;
        end
        node = scan_node;
        pos = scan_pos;
        steps = 0;
        while (node != 0 && trie_child[node][sym] == 0 && steps < MaxNodes) begin
            node = fail_of[node];
            steps++;
        end
        node = trie_child[node][sym];
        scan_node = node;
        scan_pos = (pos + 1) & 16'hffff;
        o = (pat_at[node] != 0) ? node : out_link_of[node];
        k = 0;
        while (o != 0 && pat_at[o] != 0 && k < MaxPatterns) begin
            id = pat_at[o] - 1;
            expect_beat(beat(ST_MATCH, id, (pos + 1 - pat_len[id]) & 16'hffff, 1'b0));
            k++;
            o = out_link_of[o];
        end
        if (k == 0) expect_beat(beat(ST_DONE, 0, 0, 1'b1));
        else pending_beats[$].last = 1'b1;
    endfunction

    function automatic void predict_matcher(t_in_item it);
        case (t_op'(it.operation))
            OP_SEARCH: scan_byte(it.symbol, it.text_start);
            OP_ADD: expect_beat(beat(insert_byte(it.symbol, it.word_end), 0, 0, 1'b1));
            OP_BUILD: begin
                link_trie();
                expect_beat(beat(ST_DONE, 0, 0, 1'b1));
            end
            default: expect_beat(beat(ST_DONE, 0, 0, 1'b1));
        endcase
    endfunction

    task automatic send_beat(t_in_item it);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 11);
        repeat (gap) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (!in_ready);
        predict_matcher(it);
    endtask

    function automatic t_in_item mk(t_op op, int sym, bit we, bit ts);
        t_in_item it;
        it.operation  = op;
        it.symbol     = sym[7:0];
        it.word_end   = we;
        it.text_start = ts;
        return it;
    endfunction

    function automatic int pick_sym();
        return ($urandom_range(0, 99) < 85) ? (8'h61 + $urandom_range(0, 3))
                                            : $urandom_range(0, 255);
    endfunction

    function automatic bit coin();
        return 1'($urandom_range(0, 1));
    endfunction

    // Receiver: random stall before each beat
    initial begin
        int stall;
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 11);
            repeat (stall) begin
                @(negedge i_clk);
                out_ready <= 1'b0;
            end
            @(negedge i_clk);
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!out_valid);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_valid && out_ready) begin
            if (pending_beats.size() == 0) begin
                $error("unexpected result beat %h", out_data);
                errors++;
            end else begin
                want = pending_beats.pop_front();
                if (out_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, out_data.status);
                    errors++;
                end
                if (out_data.pattern_id !== want.pattern_id) begin
                    $error("pattern_id: expected %0d, got %0d",
                           want.pattern_id, out_data.pattern_id);
                    errors++;
                end
                if (out_data.start_index !== want.start_index) begin
                    $error("start_index: expected %0d, got %0d",
                           want.start_index, out_data.start_index);
                    errors++;
                end
                if (out_data.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, out_data.last);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        t_out_item done_beat;
        int        n_sent, wlen, tlen, sym;

        foreach (trie_child[n, s]) trie_child[n][s] = 0;
        foreach (pat_at[n]) begin
            pat_at[n] = 0;
            fail_of[n] = 0;
            out_link_of[n] = 0;
        end
        foreach (pat_len[p]) pat_len[p] = 0;

        done_beat = beat(ST_DONE, 0, 0, 1'b1);
        add_row(mk(OP_NONE, 8'hff, 1'b1, 1'b1), 1'b1, done_beat);
        add_row(mk(OP_BUILD, 0, 1'b0, 1'b0), 1'b1, done_beat);
        add_row(mk(OP_SEARCH, 8'h00, 1'b1, 1'b1), 1'b1, done_beat);
        add_row(mk(OP_ADD, "a", 1'b0, 1'b1), 1'b1, done_beat);
        add_row(mk(OP_ADD, "b", 1'b1, 1'b0), 1'b1, done_beat);
        add_row(mk(OP_ADD, "b", 1'b1, 1'b0), 1'b1, done_beat);
        // same word again: keeps its first id
        add_row(mk(OP_ADD, "a", 1'b0, 1'b0), 1'b1, done_beat);
        add_row(mk(OP_ADD, "b", 1'b1, 1'b0), 1'b1, done_beat);
        add_row(mk(OP_ADD, 8'hff, 1'b1, 1'b0), 1'b1, done_beat);
        add_row(mk(OP_ADD, 8'h00, 1'b1, 1'b1), 1'b1, done_beat);
        add_row(mk(OP_BUILD, 8'hff, 1'b1, 1'b1), 1'b1, done_beat);
        add_row(mk(OP_SEARCH, "a", 1'b0, 1'b1), 1'b0, done_beat);
        add_row(mk(OP_SEARCH, "b", 1'b1, 1'b0), 1'b0, done_beat);
        add_row(mk(OP_SEARCH, 8'hff, 1'b0, 1'b0), 1'b0, done_beat);
        add_row(mk(OP_SEARCH, 8'h00, 1'b1, 1'b0), 1'b0, done_beat);
        add_row(mk(OP_SEARCH, "b", 1'b0, 1'b1), 1'b0, done_beat);
        add_row(mk(OP_SEARCH, "a", 1'b0, 1'b0), 1'b0, done_beat);
        add_row(mk(OP_SEARCH, "b", 1'b0, 1'b0), 1'b0, done_beat);
        add_row(mk(OP_NONE, 8'h55, 1'b0, 1'b0), 1'b1, done_beat);

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[r]) begin
            send_beat(rows[r].item);
            // typed rows override the prediction that was just pushed
            if (rows[r].typed) pending_beats[$] = rows[r].want;
        end

        n_sent = 0;
        while (n_sent < RandItems) begin
            if ((n_sent / 60) % 3 == 2) no_gaps = 1;
            else no_gaps = 0;
            repeat ($urandom_range(1, 3)) begin
                wlen = $urandom_range(1, 4);
                for (int i = 0; i < wlen; i++) begin
                    send_beat(mk(OP_ADD, pick_sym(), i == wlen - 1, coin()));
                    n_sent++;
                    // occasional build in the middle of a word
                    if (i < wlen - 1 && $urandom_range(0, 29) == 0) begin
                        send_beat(mk(OP_BUILD, $urandom_range(0, 255), coin(), coin()));
                        n_sent++;
                    end
                end
            end
            send_beat(mk(OP_BUILD, $urandom_range(0, 255), coin(), coin()));
            n_sent++;
            tlen = $urandom_range(10, 25);
            for (int i = 0; i < tlen; i++) begin
                if ($urandom_range(0, 32) == 0)
                    send_beat(mk(OP_NONE, $urandom_range(0, 255), coin(), coin()));
                else
                    send_beat(mk(OP_SEARCH, pick_sym(), coin(),
                                 $urandom_range(0, 9) == 0));
                n_sent++;
            end
        end

        // fill the node store, then run a few bytes past it
        no_gaps = 0;
        while (n_nodes < MaxNodes) begin
            for (int i = 0; i < 8; i++)
                send_beat(mk(OP_ADD, $urandom_range(0, 255), i == 7, 1'b0));
        end
        for (int i = 0; i < 6; i++)
            send_beat(mk(OP_ADD, $urandom_range(0, 255), i == 2 || i == 5, 1'b0));
        send_beat(mk(OP_BUILD, 0, 1'b0, 1'b0));
        for (int i = 0; i < 30; i++) begin
            sym = pick_sym();
            send_beat(mk(OP_SEARCH, sym, 1'b0, i == 0));
        end

        @(negedge i_clk);
        in_valid <= 1'b0;
        wait (pending_beats.size() == 0);
        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
